/* sv/two_level_round_robin_task_picker_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-level round-robin task picker
// Shared property templates: implication in the same cycle and in the next.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_ROUND_ROBIN_TASK_PICKER_CORE_ASSERT_SVH
`define TWO_LEVEL_ROUND_ROBIN_TASK_PICKER_CORE_ASSERT_SVH

// Check that cons holds in the cycle where ante holds.
`define TLRR_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define TLRR_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tlrr_pkg.sv */
// ----------------------------------------------------------------------------
// tlrr_pkg
// Types and fixed constants of the two-level round-robin task picker.
// ----------------------------------------------------------------------------
package tlrr_pkg;

	// Field widths fixed by the stream format
	localparam int TASK_W  = 4;
	localparam int TDATA_W = 8;

	// Item kinds carried on s_tuser
	localparam logic ACT_SET  = 1'b0;
	localparam logic ACT_PICK = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN_PRI,
		ST_SCAN_ANY,
		ST_DONE
	} tlrr_state_t;

	// Status flags of one task slot
	typedef struct packed {
		logic prio;
		logic runnable;
	} flags_t;

	localparam int FLAGS_W = $bits(flags_t);

	// One pick result
	typedef struct packed {
		logic              idle;
		logic [TASK_W-1:0] next_task;
	} res_t;

	// Sequencer status toward the stream side
	typedef struct packed {
		logic ready;
		logic res_valid;
		res_t res;
	} seq_status_t;

endpackage

/* sv/two_level_round_robin_task_picker_core.sv */
// ----------------------------------------------------------------------------
// two_level_round_robin_task_picker_core
// Two-level round-robin task picker with stream input and output.
// ----------------------------------------------------------------------------
// A set-status transaction writes both flags of one slot (slots at or above
// NUM_TASKS are ignored); it gives no result. A pick transaction holds off the
// next transaction until its result has moved into the output register: the
// sequencer reads one slot per cycle through the single read port of the flag
// RAM, first round robin over priority tasks, then, if that finds nothing new,
// over all runnable tasks. Each pick returns one result transaction; a result
// held on the output does not block further set-status transactions.
module two_level_round_robin_task_picker_core
	import tlrr_pkg::*;
#(
	parameter int NUM_TASKS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // task_index[3:0], runnable[4], is_priority[5]
	input  logic               s_tuser,  // action
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // next_task[3:0]
	output logic               m_tuser   // idle
);

	localparam int SW = $clog2(NUM_TASKS);

	logic                 s_accept;
	logic [TASK_W-1:0]    task_index;
	logic [SW+TASK_W-1:0] index_ext;
	logic                 in_range;
	logic                 wr_en;
	logic [SW-1:0]        wr_addr;
	flags_t               wr_flags;
	logic                 start;
	logic                 rd_en;
	logic [SW-1:0]        rd_addr;
	flags_t               rd_flags;
	seq_status_t          status;
	logic                 res_take;
	logic                 m_tvalid_q;
	res_t                 out_res_q;

	// Decode the input transaction
	assign s_tready         = status.ready;
	assign s_accept         = s_tvalid && s_tready;
	assign task_index       = s_tdata[TASK_W-1:0];
	assign index_ext        = {{SW{1'b0}}, task_index};
	assign in_range         = index_ext < (SW + TASK_W)'(NUM_TASKS);
	assign wr_addr          = index_ext[SW-1:0];
	assign wr_flags.runnable = s_tdata[TASK_W];
	assign wr_flags.prio     = s_tdata[TASK_W+1];
	assign wr_en            = s_accept && (s_tuser == ACT_SET) && in_range;
	assign start            = s_accept && (s_tuser == ACT_PICK);

	tlrr_table #(
		.NUM_TASKS(NUM_TASKS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_flags),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_flags)
	);

	tlrr_seq #(
		.NUM_TASKS(NUM_TASKS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.flags   (rd_flags),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.res_take(res_take),
		.status  (status)
	);

	// Move a finished result into the output register when it is free
	assign res_take = status.res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_res_q <= status.res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(TDATA_W - TASK_W){1'b0}}, out_res_q.next_task};
	assign m_tuser  = out_res_q.idle;

endmodule

/* sv/tlrr_ram.sv */
// ----------------------------------------------------------------------------
// tlrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlrr_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* sv/tlrr_table.sv */
// ----------------------------------------------------------------------------
// tlrr_table
// Per-slot runnable and priority flags: RAM plus one valid bit per slot so
// that a slot never written since reset reads as all flags clear.
// ----------------------------------------------------------------------------
module tlrr_table
	import tlrr_pkg::*;
#(
	parameter int NUM_TASKS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [$clog2(NUM_TASKS)-1:0] wr_addr,
	input  flags_t                       wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(NUM_TASKS)-1:0] rd_addr,
	output flags_t                       rd_data
);

	logic [NUM_TASKS-1:0] valid_q;
	logic                 vld_s1;
	logic [FLAGS_W-1:0]   ram_rdata;

	tlrr_ram #(
		.WIDTH(FLAGS_W),
		.DEPTH(NUM_TASKS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_rdata)
	);

	// Mark written slots; sample the valid bit alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	// Mask slots not written since reset
	assign rd_data = vld_s1 ? flags_t'(ram_rdata) : '0;

endmodule

/* sv/tlrr_seq.sv */
// ----------------------------------------------------------------------------
// tlrr_seq
// Scan sequencer: steps one slot per cycle through the flag table with a
// shared wrap-around incrementer and one match check, first over priority
// tasks, then over all runnable tasks.
// ----------------------------------------------------------------------------
`include "two_level_round_robin_task_picker_core_assert.svh"

module tlrr_seq
	import tlrr_pkg::*;
#(
	parameter int NUM_TASKS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  flags_t                       flags,
	output logic                         rd_en,
	output logic [$clog2(NUM_TASKS)-1:0] rd_addr,
	input  logic                         res_take,
	output seq_status_t                  status
);

	localparam int SW = $clog2(NUM_TASKS);
	localparam int CW = $clog2(NUM_TASKS + 1);

	tlrr_state_t state_q, state_d;

	logic [SW-1:0] ptr_q;
	logic [CW-1:0] iss_cnt_q;
	logic [CW-1:0] chk_cnt_q;
	logic [SW-1:0] slot_s1;
	logic          chk_s1;
	logic [SW-1:0] last_p_q;
	logic [SW-1:0] last_o_q;
	logic [SW-1:0] cur_q;
	res_t          res_q;

	logic             scanning;
	logic             hit;
	logic             last_miss;
	logic             pick;
	logic             to_any;
	logic             to_idle_res;
	logic             restart;
	logic             issue;
	logic [SW-1:0]    inc_in;
	logic [SW-1:0]    inc_out;
	logic [SW+TASK_W-1:0] slot_ext;
	logic [SW+TASK_W-1:0] cur_ext;

	// Shared match check on the slot whose flags just came back
	assign scanning  = (state_q == ST_SCAN_PRI) || (state_q == ST_SCAN_ANY);
	assign hit       = chk_s1 && flags.runnable && ((state_q == ST_SCAN_ANY) || flags.prio);
	assign last_miss = chk_s1 && !hit && (chk_cnt_q == CW'(NUM_TASKS - 1));
	assign pick      = hit && ((state_q == ST_SCAN_ANY) || (slot_s1 != cur_q));
	assign to_any    = (state_q == ST_SCAN_PRI) && ((hit && (slot_s1 == cur_q)) || last_miss);
	assign to_idle_res = (state_q == ST_SCAN_ANY) && last_miss;
	assign restart   = ((state_q == ST_IDLE) && start) || to_any;
	assign issue     = scanning && (iss_cnt_q != CW'(NUM_TASKS)) && !hit;

	// Shared wrap-around incrementer: scan start or next slot
	always_comb begin
		case (state_q)
			ST_IDLE:     inc_in = last_p_q;
			ST_SCAN_PRI: inc_in = to_any ? last_o_q : ptr_q;
			default:     inc_in = ptr_q;
		endcase
	end
	assign inc_out = (inc_in == SW'(NUM_TASKS - 1)) ? '0 : inc_in + SW'(1);

	assign slot_ext = {{TASK_W{1'b0}}, slot_s1};
	assign cur_ext  = {{TASK_W{1'b0}}, cur_q};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN_PRI;
				end
			end
			ST_SCAN_PRI: begin
				if (pick) begin
					state_d = ST_DONE;
				end else if (to_any) begin
					state_d = ST_SCAN_ANY;
				end
			end
			ST_SCAN_ANY: begin
				if (pick || last_miss) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		rd_en            = issue;
		rd_addr          = ptr_q;
		status.ready     = (state_q == ST_IDLE);
		status.res_valid = (state_q == ST_DONE);
		status.res       = res_q;
	end

	// Control state: pointer, counters, pick history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ptr_q     <= '0;
			iss_cnt_q <= '0;
			chk_cnt_q <= '0;
			chk_s1    <= 1'b0;
			last_p_q  <= '0;
			last_o_q  <= '0;
			cur_q     <= '0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				ptr_q     <= inc_out;
				iss_cnt_q <= '0;
				chk_cnt_q <= '0;
				chk_s1    <= 1'b0;
			end else begin
				chk_s1 <= issue;
				if (issue) begin
					ptr_q     <= inc_out;
					iss_cnt_q <= iss_cnt_q + CW'(1);
				end
				if (chk_s1) begin
					chk_cnt_q <= chk_cnt_q + CW'(1);
				end
			end
			if (pick) begin
				cur_q <= slot_s1;
				if (state_q == ST_SCAN_PRI) begin
					last_p_q <= slot_s1;
				end else begin
					last_o_q <= slot_s1;
				end
			end
		end
	end

	// Datapath: slot in flight and the result
	always_ff @(posedge clk) begin
		if (issue) begin
			slot_s1 <= ptr_q;
		end
		if (pick) begin
			res_q.idle      <= 1'b0;
			res_q.next_task <= slot_ext[TASK_W-1:0];
		end else if (to_idle_res) begin
			res_q.idle      <= 1'b1;
			res_q.next_task <= '0;
		end
	end

	`TLRR_ASSERT_IMP(a_read_bound, clk, arst_n, rd_en, iss_cnt_q < CW'(NUM_TASKS), "more reads than slots in one scan")
	`TLRR_ASSERT_NXT(a_start_scan, clk, arst_n, (state_q == ST_IDLE) && start, (state_q == ST_SCAN_PRI) && !chk_s1, "pick did not start a clean priority scan")
	`TLRR_ASSERT_NXT(a_any_hit, clk, arst_n, (state_q == ST_SCAN_ANY) && hit, (state_q == ST_DONE) && !res_q.idle, "runnable slot found but no task picked")
	`TLRR_ASSERT_IMP(a_cur_match, clk, arst_n, (state_q == ST_DONE) && !res_q.idle, res_q.next_task == cur_ext[TASK_W-1:0], "picked task differs from current task")

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for two_level_round_robin_task_picker_core
// Sends set-status and pick transactions at random pacing and checks every
// pick result against a cycle-free prediction of the two round-robin scans.
// ----------------------------------------------------------------------------
module testbench
	import tlrr_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 2 * SLOTS + 12;

	// Track slot flags and scan pointers; queue the expected pick results
	class pick_tracker;
		bit                runnable_q[SLOTS];
		bit                prio_q[SLOTS];
		logic [TASK_W-1:0] last_prio_pick;
		logic [TASK_W-1:0] last_any_pick;
		logic [TASK_W-1:0] running_task;
		res_t              expected_picks[$];
		int                mismatch_count;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				runnable_q[i] = 1'b0;
				prio_q[i]     = 1'b0;
			end
			last_prio_pick = '0;
			last_any_pick  = '0;
			running_task   = '0;
			mismatch_count = 0;
		endfunction

		// Scan round robin after start; start itself is checked last
		function bit find_slot(input int start, input bit need_prio,
				output logic [TASK_W-1:0] slot);
			int s;
			find_slot = 1'b0;
			slot = '0;
			for (int k = 1; k <= SLOTS; k++) begin
				s = (start + k) % SLOTS;
				if (!find_slot && runnable_q[s] && (!need_prio || prio_q[s])) begin
					find_slot = 1'b1;
					slot = s[TASK_W-1:0];
				end
			end
		endfunction

		function void note_item(input logic act, input logic [TASK_W-1:0] idx,
				input logic run, input logic pri);
			logic [TASK_W-1:0] slot;
			res_t              outcome;
			outcome = '0;
			if (act == ACT_SET) begin
				if (int'(idx) < SLOTS) begin
					runnable_q[idx] = run;
					prio_q[idx]     = pri;
				end
				return;
			end
			// Prefer a priority task other than the running one
			if (find_slot(last_prio_pick, 1'b1, slot) && slot != running_task) begin
				last_prio_pick    = slot;
				running_task      = slot;
				outcome.next_task = slot;
			end else if (find_slot(last_any_pick, 1'b0, slot)) begin
				last_any_pick     = slot;
				running_task      = slot;
				outcome.next_task = slot;
			end else begin
				outcome.idle = 1'b1;
			end
			expected_picks.push_back(outcome);
		endfunction

		function void check_pick(input logic [TASK_W-1:0] task_got, input logic idle_got);
			res_t want;
			if (expected_picks.size() == 0) begin
				$error("unexpected pick result: next_task %0d idle %0d", task_got, idle_got);
				mismatch_count++;
				return;
			end
			want = expected_picks.pop_front();
			if (want.next_task !== task_got) begin
				$error("next_task expected %0d actual %0d", want.next_task, task_got);
				mismatch_count++;
			end
			if (want.idle !== idle_got) begin
				$error("idle expected %0d actual %0d", want.idle, idle_got);
				mismatch_count++;
			end
		endfunction
	endclass

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;  // task_index[3:0], runnable[4], is_priority[5]
	logic               s_tuser  = 1'b0;  // action
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;  // next_task[3:0]
	logic               m_tuser;  // idle

	int          send_gap_pct   = 34;
	int          recv_stall_pct = 78;
	int          cycle_count    = 0;
	pick_tracker tracker        = new();

	two_level_round_robin_task_picker_core #(
		.NUM_TASKS(SLOTS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Check each result transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.check_pick(m_tdata[TASK_W-1:0], m_tuser);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("two_level_round_robin_task_picker_core: mismatch");
			$finish;
		end
	end

	// Send one transaction after a random gap and hold it until taken
	task automatic push_item(input logic act, input logic [TASK_W-1:0] idx,
			input logic run, input logic pri);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {2'b00, pri, run, idx};
		do @(posedge clk); while (!s_tready);
		tracker.note_item(act, idx, run, pri);
	endtask

	task automatic set_slot(input int idx, input logic run, input logic pri);
		push_item(ACT_SET, idx[TASK_W-1:0], run, pri);
	endtask

	task automatic pick_next();
		push_item(ACT_PICK, TASK_W'($urandom_range(0, SLOTS - 1)), 1'($urandom),
			1'($urandom));
	endtask

	// Hold the input until every pending pick has come back
	task automatic drain_picks();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.expected_picks.size() != 0);
	endtask

	// Random mix of status writes and picks; flag density drifts in stretches
	task automatic random_phase(input int items);
		int run_pct;
		int pri_pct;
		run_pct = 50;
		pri_pct = 40;
		for (int i = 0; i < items; i++) begin
			if (i % 30 == 0) begin
				run_pct = $urandom_range(5, 90);
				pri_pct = $urandom_range(10, 70);
			end
			if ($urandom_range(0, 99) < 40) begin
				pick_next();
			end else begin
				set_slot($urandom_range(0, SLOTS - 1), $urandom_range(0, 99) < run_pct,
					$urandom_range(0, 99) < pri_pct);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle, wrap of both scans, running priority task skipped
		pick_next();
		set_slot(0, 1'b1, 1'b0);
		pick_next();
		set_slot(15, 1'b1, 1'b1);
		pick_next();
		pick_next();
		set_slot(7, 1'b1, 1'b1);
		pick_next();
		pick_next();
		set_slot(15, 1'b0, 1'b1);
		pick_next();
		pick_next();
		set_slot(0, 1'b0, 1'b0);
		set_slot(7, 1'b0, 1'b0);
		pick_next();
		set_slot(9, 1'b1, 1'b1);
		pick_next();
		pick_next();
		set_slot(10, 1'b1, 1'b0);
		pick_next();
		pick_next();
		drain_picks();

		random_phase(150);
		drain_picks();
		send_gap_pct   = 78;
		recv_stall_pct = 34;
		random_phase(150);
		drain_picks();
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		random_phase(150);

		// Wait out the last results, then let the block settle
		drain_picks();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.expected_picks.size() == 0) begin
			$display("two_level_round_robin_task_picker_core: match");
		end else begin
			$display("two_level_round_robin_task_picker_core: mismatch");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/tlrr_pkg.sv
sv/tlrr_ram.sv
sv/tlrr_table.sv
sv/tlrr_seq.sv
sv/two_level_round_robin_task_picker_core.sv
bench/testbench.sv
